FILE: rtl/calendar_time_difference_defines.svh
// Assertion macros for the calendar time difference block.
`ifndef CALENDAR_TIME_DIFFERENCE_DEFINES_SVH
`define CALENDAR_TIME_DIFFERENCE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CTD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ctd_pkg.sv
// Shared types, constants and month table for the calendar time difference block.
`timescale 1ns / 1ps

package ctd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;

  localparam int DNUM_W   = 23;  // day number of one timestamp
  localparam int MOD_W    = 11;  // minute of day, unnormalized up to 1923
  localparam int DDIFF_W  = 25;  // signed day difference after normalizing
  localparam int DAYS_W   = 22;

  localparam logic [MOD_W-1:0]   MIN_PER_DAY  = 11'd1440;
  localparam logic [MOD_W-1:0]   MIN_PER_HOUR = 11'd60;
  localparam logic [DDIFF_W-1:0] DAYS_MAX     = 25'h03F_FFFF;

  // floor(x / 25) = (x * 2622) >> 16 for x < 4096
  localparam logic [11:0] RECIP_25 = 12'd2622;
  // floor(x / 60) = (x * 1093) >> 16 for x < 1440
  localparam logic [10:0] RECIP_60 = 11'd1093;

  localparam logic [8:0] DAYS_BEFORE_MONTH [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef struct packed {
    logic s1;
    logic s2;
  } ctd_stage_en_t;

  // Whole months ahead of the given month, clamped to a full year.
  function automatic logic [3:0] months_before(input logic [MONTH_W-1:0] mo);
    logic [3:0] mb;
    mb = (mo == '0) ? 4'd0 : (mo - 4'd1);
    if (mb > 4'd12) begin
      mb = 4'd12;
    end
    return mb;
  endfunction

endpackage

FILE: rtl/ctd_day_count.sv
// Two-stage conversion of one timestamp into a day number and a minute of day.
`timescale 1ns / 1ps

module ctd_day_count
  import ctd_pkg::*;
(
  input  logic                clk,
  input  ctd_stage_en_t       en,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DAY_W-1:0]    day,
  input  logic [HOUR_W-1:0]   hour,
  input  logic [MINUTE_W-1:0] minute,
  output logic [DNUM_W-1:0]   day_num,
  output logic [MOD_W-1:0]    min_of_day
);

  logic [YEAR_W-1:0]   prev_year_next;
  logic [23:0]         prev_prod;
  logic [23:0]         year_prod;

  logic [YEAR_W-1:0]   prev_year;
  logic [7:0]          prev_q100;
  logic [YEAR_W-1:0]   year1;
  logic [7:0]          year_q100;
  logic [MONTH_W-1:0]  month1;
  logic [DAY_W-1:0]    day1;
  logic [MOD_W-1:0]    mod1;

  logic [11:0]         leaps;
  logic [11:0]         rem25;
  logic                div4;
  logic                div100;
  logic                div400;
  logic                leap;
  logic [3:0]          mb;
  logic [DNUM_W-1:0]   day_num_next;

  assign prev_year_next = (year == '0) ? '0 : (year - 14'd1);
  assign prev_prod = {12'd0, prev_year_next[YEAR_W-1:2]} * {12'd0, RECIP_25};
  assign year_prod = {12'd0, year[YEAR_W-1:2]} * {12'd0, RECIP_25};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prev_year <= prev_year_next;
      prev_q100 <= prev_prod[23:16];
      year1     <= year;
      year_q100 <= year_prod[23:16];
      month1    <= month;
      day1      <= day;
      mod1      <= MOD_W'({6'd0, hour} * MIN_PER_HOUR) + {5'd0, minute};
    end
  end

  always_comb begin
    leaps  = prev_year[YEAR_W-1:2] - {4'd0, prev_q100} + {6'd0, prev_q100[7:2]};
    rem25  = year1[YEAR_W-1:2] - 12'({4'd0, year_q100} * 12'd25);
    div4   = (year1[1:0] == 2'b00);
    div100 = div4 && (rem25 == '0);
    div400 = div100 && (year_q100[1:0] == 2'b00);
    leap   = (div4 && !div100) || div400;
    mb     = months_before(month1);
    day_num_next = DNUM_W'({9'd0, prev_year} * 23'd365) + {11'd0, leaps}
                 + {14'd0, DAYS_BEFORE_MONTH[mb]}
                 + {22'd0, (mb >= 4'd2) && leap} + {18'd0, day1};
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      day_num    <= day_num_next;
      min_of_day <= mod1;
    end
  end

endmodule

FILE: rtl/calendar_time_difference.sv
// Calendar time difference: top level, pipeline control and difference stages.
//
// Input channel: in_valid/in_stall with start_* and stop_* timestamp fields.
// An item is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with diff_days, diff_hours and
// diff_minutes, the absolute difference of the two timestamps.
// Items move through five register stages to out_valid. Throughput: one
// item per cycle while out_stall is low; the register stages each advance
// whenever the stage ahead is empty or moving, so bubbles are squeezed out.
// Day numbers come from closed-form leap counting with reciprocal multiplies.
// diff_days saturates at 4194303 for out-of-range years.
// Reset (rst, synchronous, active high) clears all valid bits; no item is
// in flight afterwards and in_stall is low.
// While out_stall is high the result holds steady; upstream stages keep
// filling until the pipe is full, then in_stall rises.
`timescale 1ns / 1ps

`include "calendar_time_difference_defines.svh"

module calendar_time_difference
  import ctd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [YEAR_W-1:0]   start_year,
  input  logic [MONTH_W-1:0]  start_month,
  input  logic [DAY_W-1:0]    start_day,
  input  logic [HOUR_W-1:0]   start_hour,
  input  logic [MINUTE_W-1:0] start_minute,
  input  logic [YEAR_W-1:0]   stop_year,
  input  logic [MONTH_W-1:0]  stop_month,
  input  logic [DAY_W-1:0]    stop_day,
  input  logic [HOUR_W-1:0]   stop_hour,
  input  logic [MINUTE_W-1:0] stop_minute,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DAYS_W-1:0]   diff_days,
  output logic [HOUR_W-1:0]   diff_hours,
  output logic [MINUTE_W-1:0] diff_minutes
);

  localparam int STAGES = 5;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] adv;
  ctd_stage_en_t     sub_en;

  logic [DNUM_W-1:0] start_dnum;
  logic [DNUM_W-1:0] stop_dnum;
  logic [MOD_W-1:0]  start_mod;
  logic [MOD_W-1:0]  stop_mod;

  logic signed [DDIFF_W-1:0] dd;
  logic signed [11:0]        mm;
  logic signed [DDIFF_W-1:0] d3_next;
  logic [MOD_W-1:0]          m3_next;
  logic signed [DDIFF_W-1:0] d3;
  logic [MOD_W-1:0]          m3;

  logic [DDIFF_W-1:0] neg_d;
  logic [DDIFF_W-1:0] days_raw;
  logic [MOD_W-1:0]   rest4_next;
  logic [DAYS_W-1:0]  days4;
  logic [MOD_W-1:0]   rest4;

  logic [21:0]         hour_prod;
  logic [HOUR_W-1:0]   hours_next;
  logic [MOD_W-1:0]    hour_min;
  logic [MOD_W-1:0]    minutes_next;

  always_comb begin
    adv[STAGES-1] = !valid[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = valid[STAGES-1];
  assign sub_en    = '{s1: adv[0], s2: adv[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  ctd_day_count u_start (
    .clk        (clk),
    .en         (sub_en),
    .year       (start_year),
    .month      (start_month),
    .day        (start_day),
    .hour       (start_hour),
    .minute     (start_minute),
    .day_num    (start_dnum),
    .min_of_day (start_mod)
  );

  ctd_day_count u_stop (
    .clk        (clk),
    .en         (sub_en),
    .year       (stop_year),
    .month      (stop_month),
    .day        (stop_day),
    .hour       (stop_hour),
    .minute     (stop_minute),
    .day_num    (stop_dnum),
    .min_of_day (stop_mod)
  );

  // normalize minute of day into 0..1439, carrying into the day difference
  always_comb begin
    dd = $signed({2'b00, stop_dnum}) - $signed({2'b00, start_dnum});
    mm = $signed({1'b0, stop_mod}) - $signed({1'b0, start_mod});
    if (mm < -12'sd1440) begin
      d3_next = dd - 25'sd2;
      m3_next = MOD_W'(mm + 12'sd1440 + 12'sd1440);
    end else if (mm < 12'sd0) begin
      d3_next = dd - 25'sd1;
      m3_next = MOD_W'(mm + 12'sd1440);
    end else if (mm >= 12'sd1440) begin
      d3_next = dd + 25'sd1;
      m3_next = MOD_W'(mm - 12'sd1440);
    end else begin
      d3_next = dd;
      m3_next = MOD_W'(mm);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d3 <= d3_next;
      m3 <= m3_next;
    end
  end

  always_comb begin
    neg_d = -d3;
    if (d3 < 0) begin
      if (m3 == '0) begin
        days_raw   = neg_d;
        rest4_next = '0;
      end else begin
        days_raw   = neg_d - 25'd1;
        rest4_next = MIN_PER_DAY - m3;
      end
    end else begin
      days_raw   = d3;
      rest4_next = m3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      days4 <= (days_raw > DAYS_MAX) ? DAYS_MAX[DAYS_W-1:0] : days_raw[DAYS_W-1:0];
      rest4 <= rest4_next;
    end
  end

  always_comb begin
    hour_prod    = {11'd0, rest4} * {11'd0, RECIP_60};
    hours_next   = hour_prod[20:16];
    hour_min     = {hours_next, 6'd0} - {4'd0, hours_next, 2'd0};
    minutes_next = rest4 - hour_min;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      diff_days    <= days4;
      diff_hours   <= hours_next;
      diff_minutes <= minutes_next[MINUTE_W-1:0];
    end
  end

  `CTD_ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && !in_stall, valid[0], "accepted item lost")
  `CTD_ASSERT_IMPLY(a_rest_norm, clk, rst, valid[2], m3 < MIN_PER_DAY, "minute of day not normalized")
  `CTD_ASSERT_IMPLY(a_hours_range, clk, rst, out_valid, diff_hours <= 5'd23, "hours out of range")
  `CTD_ASSERT_IMPLY(a_min_range, clk, rst, out_valid, diff_minutes <= 6'd59, "minutes out of range")

endmodule
